@@ rtl/tfv_pkg.sv @@
// tfv_pkg: shared types, character codes and date helpers for the text field validator
// no dependencies; imported by text_field_validator_unit
package tfv_pkg;

   typedef enum logic [1:0] {
      KIND_DATE    = 2'd0,
      KIND_INT     = 2'd1,
      KIND_DEC     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int YEAR_W     = 14;
   localparam int DATE_W     = 7;
   localparam int POS_W      = 4;

   // register index is the word address
   localparam logic REG_EARLIEST_YEAR = 1'b0;

   localparam logic [YEAR_W-1:0] EARLIEST_YEAR_RESET = 14'd1500;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_POINT = 8'h2e;

   localparam logic [POS_W-1:0] POS_MAX       = 4'd15;
   localparam logic [POS_W-1:0] POS_DATE_LEN  = 4'd8;
   localparam logic [POS_W-1:0] POS_MONTH_1ST = 4'd4;
   localparam logic [POS_W-1:0] POS_DAY_1ST   = 4'd6;

   // month length, leap flag decided by the caller
   function automatic logic [DATE_W-1:0] days_in_month(input logic [DATE_W-1:0] month,
                                                      input logic leap);
      logic [DATE_W-1:0] days;
      case (month)
         7'd4, 7'd6, 7'd9, 7'd11: days = 7'd30;
         7'd2:                    days = leap ? 7'd29 : 7'd28;
         default:                 days = 7'd31;
      endcase
      return days;
   endfunction

endpackage

@@ rtl/text_field_validator_unit.sv @@
// text_field_validator_unit: character-serial validator for date, integer and decimal fields
// depends on tfv_pkg (kinds, character codes, month lengths)
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    command, character, empty_field, last
//   rsp       out        rsp_valid/rsp_ready    invalid (one item per field)
//   csr       in         psel/penable/pwrite    earliest_year at byte address 0
//
// one character per cycle if no close stalls: input register, field state, result register
// a result is registered when the closing character leaves the input register
// reset clears field state and restores earliest_year to 1500
// a stalled result holds back only an input item that closes a field
module text_field_validator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_command,
   input  logic [7:0]                   req_character,
   input  logic                         req_empty_field,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_invalid,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tfv_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tfv_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tfv_pkg::CSR_DATA_W-1:0] prdata,
   output logic                         pready
);
   import tfv_pkg::*;

   // configuration
   logic [YEAR_W-1:0] earliest_ff, earliest_in;
   logic              csr_write;

   // input register
   logic              in_valid_ff, in_valid_in;
   kind_type          cmd_ff;
   logic [7:0]        char_ff;
   logic              empty_ff, last_ff;

   // field state
   logic [POS_W-1:0]  pos_ff, pos_in;
   kind_type          kind_ff, kind_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [DATE_W-1:0] month_ff, month_in;
   logic [DATE_W-1:0] day_ff, day_in;
   logic              seen_ff, seen_in;
   logic              bad_ff, bad_in;
   logic              sign_ff, sign_in;
   logic              low_zero_ff, low_zero_in;
   logic [1:0]        cent_mod4_ff, cent_mod4_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_invalid_ff, rsp_invalid_in;

   logic              first, digit, sign, point, closes, advance;
   logic [3:0]        digit_val;
   logic [YEAR_W-1:0] year_step;
   logic [DATE_W-1:0] month_step, day_step;
   logic [POS_W-1:0]  pos_step;
   logic              leap, date_bad, invalid_now;
   kind_type          kind_now;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_EARLIEST_YEAR)
                      ? {{(CSR_DATA_W-YEAR_W){1'b0}}, earliest_ff} : '0;

   always_comb begin
      earliest_in = earliest_ff;
      if (csr_write && paddr[2] == REG_EARLIEST_YEAR) begin
         earliest_in = pwdata[YEAR_W-1:0];
      end
   end

   // handshake and flow
   assign closes    = empty_ff || last_ff;
   assign advance   = in_valid_ff && (!closes || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   // character classes
   assign digit     = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign sign      = (char_ff == CHAR_PLUS) || (char_ff == CHAR_MINUS);
   assign point     = (char_ff == CHAR_POINT);
   assign digit_val = 4'(char_ff - CHAR_ZERO);

   // state is already clear at position zero, only the kind is taken fresh
   assign first    = (pos_ff == '0);
   assign kind_now = first ? cmd_ff : kind_ff;
   assign pos_step = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;

   assign year_step  = YEAR_W'(year_ff * 4'd10) + YEAR_W'(digit_val);
   assign month_step = DATE_W'(month_ff * 4'd10) + DATE_W'(digit_val);
   assign day_step   = DATE_W'(day_ff * 4'd10) + DATE_W'(digit_val);

   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      seen_in      = seen_ff;
      bad_in       = bad_ff;
      sign_in      = sign_ff;
      low_zero_in  = low_zero_ff;
      cent_mod4_in = cent_mod4_ff;
      case (kind_now)
         KIND_DATE: begin
            if (!digit || pos_ff >= POS_DATE_LEN) begin
               bad_in = 1'b1;
            end else if (pos_ff < POS_MONTH_1ST) begin
               year_in = year_step;
               // track the century digits mod 4 and whether the low two digits are zero
               if (pos_ff == 4'd1) cent_mod4_in = year_step[1:0];
               if (pos_ff == 4'd2) low_zero_in = (digit_val == 4'd0);
               if (pos_ff == 4'd3) low_zero_in = low_zero_ff && (digit_val == 4'd0);
            end else if (pos_ff < POS_DAY_1ST) begin
               month_in = month_step;
            end else begin
               day_in = day_step;
            end
         end
         KIND_INT: begin
            if (first) begin
               if (sign) sign_in = 1'b1;
               else if (!digit) bad_in = 1'b1;
            end else if (!digit) begin
               bad_in = 1'b1;
            end
         end
         KIND_DEC: begin
            if (point) begin
               if (seen_ff) bad_in = 1'b1;
               seen_in = 1'b1;
            end else if (first) begin
               if (!sign && !digit) bad_in = 1'b1;
            end else if (!digit) begin
               bad_in = 1'b1;
            end
         end
         default: bad_in = 1'b1;
      endcase
   end

   // year is final once the month digits start, so the leap flag comes from registers
   assign leap = (year_ff[1:0] == 2'd0) && (!low_zero_ff || cent_mod4_ff == 2'd0);

   assign date_bad = bad_in || pos_step != POS_DATE_LEN || year_ff < earliest_ff
                     || month_ff < 7'd1 || month_ff > 7'd12
                     || day_in < 7'd1 || day_in > days_in_month(month_ff, leap);

   always_comb begin
      case (kind_now)
         KIND_DATE: invalid_now = date_bad;
         KIND_INT:  invalid_now = bad_in || (sign_in && pos_step == 4'd1);
         KIND_DEC:  invalid_now = bad_in;
         default:   invalid_now = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_invalid_in = rsp_invalid_ff;
      if (advance && closes) begin
         rsp_valid_in   = 1'b1;
         rsp_invalid_in = empty_ff ? 1'b1 : invalid_now;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         cmd_ff   <= kind_type'(req_command);
         char_ff  <= req_character;
         empty_ff <= req_empty_field;
         last_ff  <= req_last;
      end
      rsp_invalid_ff <= rsp_invalid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         earliest_ff  <= EARLIEST_YEAR_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         kind_ff      <= KIND_DATE;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         seen_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         sign_ff      <= 1'b0;
         low_zero_ff  <= 1'b0;
         cent_mod4_ff <= '0;
      end else begin
         earliest_ff  <= earliest_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (closes) begin
               pos_ff       <= '0;
               kind_ff      <= KIND_DATE;
               year_ff      <= '0;
               month_ff     <= '0;
               day_ff       <= '0;
               seen_ff      <= 1'b0;
               bad_ff       <= 1'b0;
               sign_ff      <= 1'b0;
               low_zero_ff  <= 1'b0;
               cent_mod4_ff <= '0;
            end else begin
               pos_ff       <= pos_in;
               kind_ff      <= kind_in;
               year_ff      <= year_in;
               month_ff     <= month_in;
               day_ff       <= day_in;
               seen_ff      <= seen_in;
               bad_ff       <= bad_in;
               sign_ff      <= sign_in;
               low_zero_ff  <= low_zero_in;
               cent_mod4_ff <= cent_mod4_in;
            end
         end
      end
   end

   assign pos_in  = pos_step;
   assign kind_in = kind_now;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_invalid = rsp_invalid_ff;

   // a field in progress never starts from leftover state
   a_clear_at_start: assert property (@(posedge clock) disable iff (reset)
      pos_ff == '0 |-> !bad_ff && !seen_ff && !sign_ff && year_ff == '0 && day_ff == '0)
      else $error("field state not clear at position zero");

   a_sign_only_int: assert property (@(posedge clock) disable iff (reset)
      sign_ff |-> kind_ff == KIND_INT && pos_ff != '0)
      else $error("sign flag outside an integer field");

   a_point_only_dec: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> kind_ff == KIND_DEC)
      else $error("point flag outside a decimal field");

   a_close_gives_item: assert property (@(posedge clock) disable iff (reset)
      advance && closes |=> rsp_valid_ff)
      else $error("closing item produced no result");

   a_stall_only_on_close: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> closes && rsp_valid_ff && !rsp_ready)
      else $error("input stage stalled without a blocked result");

endmodule
